>>> rtl/ecspr_pkg.sv
package ecspr_pkg;

  localparam logic [15:0] SLOT_TICKS_RESET  = 16'd12500;
  localparam logic [7:0]  ENABLE_RESET      = 8'd255;
  localparam logic [15:0] RAMP_UNIT_RESET   = 16'd500;
  localparam logic [15:0] INIT_WIDTH_RESET  = 16'd2400;
  localparam logic [7:0]  SPEED_RESET       = 8'd1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  localparam logic [1:0] REG_SLOT_TICKS = 2'd0;
  localparam logic [1:0] REG_ENABLE     = 2'd1;
  localparam logic [1:0] REG_RAMP_UNIT  = 2'd2;
  localparam logic [1:0] REG_INIT_WIDTH = 2'd3;

  typedef struct packed {
    logic        op;
    logic [2:0]  channel;
    logic [15:0] target_width;
    logic [7:0]  ramp_speed;
  } item_t;

  typedef struct packed {
    logic [7:0] servo_pins;
    logic [2:0] active_channel;
    logic [7:0] ramping;
  } result_t;

  // Shared controls that every channel cell sees in the same cycle.
  typedef struct packed {
    logic        tick;
    logic        ramp_pulse;
    logic        slot_end;
    logic        load;
    logic [15:0] set_width;
    logic [7:0]  set_speed;
    logic [15:0] load_width;
    logic [15:0] slot_count;
  } cell_ctl_t;

endpackage

>>> rtl/eight_channel_servo_pulse_ramp.sv
// A result is registered in the output register (or the skid entry when stalled).
// Throughput: one item per cycle while the skid entry is empty; each channel
// cell updates its width, ramp counter and slot token in the cycle of the item,
// and a skid register lets an item in while the previous result is stalled.
// Reset (rst, synchronous): registers to defaults, every width and target to
// 2400, slot on channel 0, pins low, no result pending.
module eight_channel_servo_pulse_ramp import ecspr_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0] slot_ticks;
  logic [7:0]  channel_enable;
  logic [15:0] ramp_unit;
  logic [15:0] slot_count;
  logic [15:0] prescaler;
  logic [CW-1:0] slot_channel;
  logic [7:0]  pin_levels;

  logic        accept;
  logic        tick;
  logic        set;
  logic [15:0] len;
  logic [15:0] unit;
  logic [16:0] slot_inc;
  logic [16:0] pre_inc;
  logic        slot_end;
  logic        pre_end;
  logic [15:0] tw_sat;
  logic [15:0] chan_wide;
  cell_ctl_t   ctl;

  logic [CHANNELS-1:0] token;
  logic [CHANNELS-1:0] pin;
  logic [CHANNELS-1:0] ramp_bit;
  logic [CHANNELS-1:0] set_hit;
  logic [CHANNELS-1:0] enable;
  logic [7:0]  pins_now;
  logic [7:0]  ramp_vec;
  result_t     fresh;
  result_t     skid;
  logic        skid_valid;

  assign item_stall = skid_valid;
  assign accept     = item_valid & ~skid_valid;
  assign tick       = accept & (item.op == OP_TICK);
  assign set        = accept & (item.op == OP_SET);

  assign len      = (slot_ticks == 16'd0) ? 16'd1 : slot_ticks;
  assign unit     = (ramp_unit == 16'd0) ? 16'd1 : ramp_unit;
  assign slot_inc = {1'b0, slot_count} + 17'd1;
  assign pre_inc  = {1'b0, prescaler} + 17'd1;
  assign slot_end = (slot_inc >= {1'b0, len});
  assign pre_end  = (pre_inc >= {1'b0, unit});
  assign tw_sat   = (item.target_width > len) ? len : item.target_width;

  always_comb begin
    ctl.tick       = tick;
    ctl.ramp_pulse = tick & pre_end;
    ctl.slot_end   = slot_end;
    ctl.load       = cfg_write & (cfg_index == REG_INIT_WIDTH);
    ctl.set_width  = tw_sat;
    ctl.set_speed  = item.ramp_speed;
    ctl.load_width = cfg_data;
    ctl.slot_count = slot_count;
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    assign set_hit[i] = set & (int'(item.channel) == i);
    if (i < 8) begin : g_en
      assign enable[i] = channel_enable[i];
    end else begin : g_off
      assign enable[i] = 1'b0;
    end
    ecspr_cell #(
      .FIRST (i == 0)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .set_hit    (set_hit[i]),
      .enable     (enable[i]),
      .token_prev (token[(i + CHANNELS - 1) % CHANNELS]),
      .token      (token[i]),
      .pin        (pin[i]),
      .ramping    (ramp_bit[i])
    );
  end

  // Only the first eight channels reach the result fields.
  for (genvar c = 0; c < 8; c++) begin : g_out
    if (c < CHANNELS) begin : g_on
      assign pins_now[c] = pin[c];
      assign ramp_vec[c] = ramp_bit[c];
    end else begin : g_zero
      assign pins_now[c] = 1'b0;
      assign ramp_vec[c] = 1'b0;
    end
  end

  assign chan_wide = 16'(slot_channel);

  always_comb begin
    fresh.servo_pins     = tick ? pins_now : pin_levels;
    fresh.active_channel = chan_wide[2:0];
    fresh.ramping        = ramp_vec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks     <= SLOT_TICKS_RESET;
      channel_enable <= ENABLE_RESET;
      ramp_unit      <= RAMP_UNIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SLOT_TICKS: slot_ticks     <= cfg_data;
        REG_ENABLE:     channel_enable <= cfg_data[7:0];
        REG_RAMP_UNIT:  ramp_unit      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count   <= 16'd0;
      prescaler    <= 16'd0;
      slot_channel <= '0;
      pin_levels   <= 8'd0;
    end else if (tick) begin
      pin_levels <= pins_now;
      if (slot_end) begin
        slot_count   <= 16'd0;
        slot_channel <= (slot_channel == CW'(CHANNELS - 1)) ? '0 : slot_channel + 1'b1;
      end else begin
        slot_count <= slot_inc[15:0];
      end
      prescaler <= pre_end ? 16'd0 : pre_inc[15:0];
    end
  end

  // Output register plus one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result <= skid_valid ? skid : fresh;
    end else if (accept) begin
      skid <= fresh;
    end
  end

endmodule

>>> rtl/ecspr_cell.sv
module ecspr_cell import ecspr_pkg::*; #(
  parameter bit FIRST = 1'b0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      set_hit,
  input  logic      enable,
  input  logic      token_prev,
  output logic      token,
  output logic      pin,
  output logic      ramping
);

  logic [15:0] width;
  logic [15:0] width_next;
  logic [15:0] target;
  logic [15:0] target_next;
  logic [7:0]  speed;
  logic [7:0]  speed_next;
  logic [7:0]  count;
  logic [7:0]  count_next;
  logic [7:0]  count_inc;
  logic        token_next;

  assign count_inc = count + 8'd1;

  always_comb begin
    width_next  = width;
    target_next = target;
    speed_next  = speed;
    count_next  = count;
    token_next  = token;
    if (set_hit) begin
      target_next = ctl.set_width;
      speed_next  = ctl.set_speed;
      count_next  = 8'd0;
      if (ctl.set_speed == 8'd0) begin
        width_next = ctl.set_width;
      end
    end
    if (ctl.tick) begin
      // The slot token moves one cell down the ring when a slot ends.
      if (ctl.slot_end) begin
        token_next = token_prev;
      end
      if (ctl.ramp_pulse) begin
        if (width == target) begin
          count_next = 8'd0;
        end else if (speed == 8'd0) begin
          width_next = target;
          count_next = 8'd0;
        end else if (count_inc >= speed) begin
          count_next = 8'd0;
          width_next = (width < target) ? width + 16'd1 : width - 16'd1;
        end else begin
          count_next = count_inc;
        end
      end
    end
  end

  assign pin     = ctl.tick & token & enable & (ctl.slot_count < width);
  assign ramping = (width_next != target_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      token  <= FIRST;
      width  <= INIT_WIDTH_RESET;
      target <= INIT_WIDTH_RESET;
      speed  <= SPEED_RESET;
      count  <= 8'd0;
    end else if (ctl.load) begin
      width  <= ctl.load_width;
      target <= ctl.load_width;
      count  <= 8'd0;
    end else begin
      token  <= token_next;
      width  <= width_next;
      target <= target_next;
      speed  <= speed_next;
      count  <= count_next;
    end
  end

endmodule

>>> rtl/ecspr_checker.sv
module ecspr_checker import ecspr_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // Nothing is pending right after reset.
  assert property (@(posedge clk) rst |=> !result_valid && !item_stall)
    else $error("result or stall active after reset");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // At most one servo pin is high at a time.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(result.servo_pins))
    else $error("more than one servo pin high");

  // An item taken while the result is held back fills the skid entry.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && result_valid && result_stall |=> item_stall)
    else $error("input not stalled with skid entry full");

  // The input side only stalls while a result is pending.
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with no result pending");

endmodule

bind eight_channel_servo_pulse_ramp ecspr_checker u_ecspr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
